FILE: src/wsmf_pkg.sv
`timescale 1ns / 1ps

package wsmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W = 2;
  localparam int MAG_W = SAMPLE_W - 1;
  localparam int MAX_WINDOW = 64;
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW) + 1;
  localparam int TDATA_W = ((SAMPLE_W + IDX_W + 7) / 8) * 8;
  localparam int WINDOW_LENGTH_DEF = 8;
  localparam int WHEEL_COUNT_DEF = 4;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef struct packed {
    logic                       valid;
    logic                       ok;
    logic [IDX_W-1:0]           wheel;
    logic signed [SAMPLE_W-1:0] carry;
    logic                       carry_vld;
    logic [MAG_W-1:0]           best;
    logic signed [SUM_W-1:0]    sum;
  } tok_t;

  function automatic logic [MAG_W-1:0] sat_mag(input logic signed [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] neg;
    logic [MAG_W-1:0]    res;
    neg = SAMPLE_W'(-x);
    if (x == {1'b1, {MAG_W{1'b0}}}) begin
      res = MAG_MAX;
    end else if (x < 0) begin
      res = neg[MAG_W-1:0];
    end else begin
      res = x[MAG_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/wheel_speed_window_min_filter_top.sv
`timescale 1ns / 1ps
// Per-wheel sliding-window minimum-magnitude filter for signed Q8.8 wheel speeds.
// Input stream (s_axis): one word per sample, wheel_sample in bits 15:0 and
// wheel_index in bits 17:16. Output stream (m_axis): one word per input word,
// in input order, filtered_speed in bits 15:0 and wheel_tag in bits 17:16.
// Each wheel keeps its last WINDOW_LENGTH samples. The result is the smallest
// magnitude in the window, negated when the window sum is negative; a wheel
// index not below WHEEL_COUNT leaves all windows untouched and returns zero.
// The window is a row of WINDOW_LENGTH cells. A word walks down the row one cell
// per cycle while the row advances, swapping its sample with the one stored for
// its wheel and folding the sample it carried in into a running minimum and sum.
// A word passes through each cell's register and then the output register before
// m_axis_tvalid; one word per cycle is accepted while the output side keeps up.
// When the receiver stalls with a word pending, the whole row holds and
// s_axis_tready drops in the same cycle.
// After reset every wheel's window holds a single zero sample and no word is
// in flight.
module wheel_speed_window_min_filter_top import wsmf_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int WHEEL_COUNT = WHEEL_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // wheel_sample[15:0], wheel_index[17:16]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata   // filtered_speed[15:0], wheel_tag[17:16]
);

  tok_t             tok [WINDOW_LENGTH+1];
  tok_t             tok_in;
  logic             adv;
  logic [IDX_W-1:0] wheel;

  assign wheel = s_axis_tdata[SAMPLE_W +: IDX_W];

  always_comb begin
    tok_in.valid     = s_axis_tvalid && adv;
    tok_in.ok        = 32'(wheel) < WHEEL_COUNT;
    tok_in.wheel     = wheel;
    tok_in.carry     = s_axis_tdata[SAMPLE_W-1:0];
    tok_in.carry_vld = 1'b1;
    tok_in.best      = MAG_MAX;
    tok_in.sum       = '0;
  end

  assign tok[0] = tok_in;

  for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
    wsmf_cell #(
      .WHEEL_COUNT (WHEEL_COUNT),
      .INIT_VALID  (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  wsmf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (tok[WINDOW_LENGTH]),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .adv_o         (adv)
  );

  assign s_axis_tready = adv;

endmodule

FILE: src/wsmf_cell.sv
`timescale 1ns / 1ps

module wsmf_cell import wsmf_pkg::*; #(
  parameter int WHEEL_COUNT = WHEEL_COUNT_DEF,
  parameter bit INIT_VALID = 1'b0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  localparam int WSEL_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  logic signed [SAMPLE_W-1:0] sample_q [WHEEL_COUNT];
  logic                       vld_q    [WHEEL_COUNT];
  logic [WSEL_W-1:0]          sel;
  logic signed [SAMPLE_W-1:0] rd_sample;
  logic                       rd_vld;
  logic [MAG_W-1:0]           mag;
  tok_t                       tok_d;
  tok_t                       tok_q;

  assign sel = WSEL_W'(tok_i.wheel);
  assign mag = sat_mag(tok_i.carry);

  always_comb begin
    rd_sample = tok_i.carry;
    rd_vld    = tok_i.carry_vld;
    tok_d     = tok_i;
    if (tok_i.ok) begin
      rd_sample = sample_q[sel];
      rd_vld    = vld_q[sel];
      tok_d.carry     = rd_sample;
      tok_d.carry_vld = rd_vld;
      if (tok_i.carry_vld) begin
        if (mag < tok_i.best) begin
          tok_d.best = mag;
        end
        tok_d.sum = tok_i.sum + SUM_W'(tok_i.carry);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        sample_q[w] <= '0;
        vld_q[w]    <= INIT_VALID;
      end
    end else if (adv_i && tok_i.valid && tok_i.ok) begin
      sample_q[sel] <= tok_i.carry;
      vld_q[sel]    <= tok_i.carry_vld;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: src/wsmf_out.sv
`timescale 1ns / 1ps

module wsmf_out import wsmf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tok_t               tok_i,
  input  logic               m_axis_tready,
  output logic               m_axis_tvalid,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               adv_o
);

  logic                       valid_q;
  logic [TDATA_W-1:0]         data_q;
  logic [TDATA_W-1:0]         data_d;
  logic signed [SAMPLE_W-1:0] speed;
  logic [SAMPLE_W-1:0]        best_ext;

  assign adv_o    = !valid_q || m_axis_tready;
  assign best_ext = {1'b0, tok_i.best};

  always_comb begin
    if (!tok_i.ok) begin
      speed = '0;
    end else if (tok_i.sum < 0) begin
      speed = SAMPLE_W'(-best_ext);
    end else begin
      speed = best_ext;
    end
    data_d = TDATA_W'({tok_i.wheel, speed});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else if (adv_o) begin
      valid_q <= tok_i.valid;
      data_q  <= data_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

FILE: src/wsmf_chk.sv
`timescale 1ns / 1ps

module wsmf_chk import wsmf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output word changed.");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("Input accepted while output is stalled.");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input not ready with an empty output register.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[SAMPLE_W-1:0] != {1'b1, {MAG_W{1'b0}}})
    else $error("Filtered speed outside the saturated range.");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:SAMPLE_W+IDX_W] == '0)
    else $error("Output padding bits not zero.");

endmodule

bind wheel_speed_window_min_filter_top wsmf_chk u_wsmf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
